// ===== rtl/xcr_pkg.sv =====
`default_nettype none
package xcr_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 128;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_SUB = 8'h1A;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_FF  = 8'hFF;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_BLOCK  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TIMEOUT  = 2'd1;
   localparam logic [1:0] ST_CANCEL   = 2'd2;
   localparam logic [1:0] ST_SEQ      = 2'd3;

   localparam logic [1:0] REG_INIT_TO   = 2'd0;
   localparam logic [1:0] REG_BYTE_TO   = 2'd1;
   localparam logic [1:0] REG_HEADER_TO = 2'd2;
   localparam logic [1:0] REG_RETRIES   = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
      logic [1:0] read_buffer;
      logic [6:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [1:0] buffer_id;
      logic [7:0] block_length;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // up to three results per item
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
   } batch_type;

   typedef struct packed {
      logic [15:0] init_to;
      logic [15:0] byte_to;
      logic [15:0] header_to;
      logic [7:0]  retries;
   } cfg_type;

   // one byte through crc-16/xmodem
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

   function automatic rsp_type mk(input logic [1:0] k, input logic [7:0] b,
                                  input logic [1:0] id, input logic [7:0] len,
                                  input logic [1:0] st);
      rsp_type r;
      r.out_kind = k;
      r.out_byte = b;
      r.buffer_id = id;
      r.block_length = len;
      r.status = st;
      r.last = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/xcr_store.sv =====
`default_nettype none
module xcr_store #(
   parameter int BLOCK_BYTES = xcr_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [1:0]                     wr_slot,
   input  wire logic [$clog2(BLOCK_BYTES)-1:0] wr_index,
   input  wire logic [7:0]                     wr_data,
   input  wire logic [1:0]                     rd_slot,
   input  wire logic [$clog2(BLOCK_BYTES)-1:0] rd_index,
   output logic [7:0]                          rd_data
);
   localparam int AW = $clog2(3 * BLOCK_BYTES);

   logic [7:0] mem [3*BLOCK_BYTES];
   logic [AW-1:0] wa, ra;

   assign wa = AW'(wr_slot) * AW'(BLOCK_BYTES) + AW'(wr_index);
   assign ra = AW'(rd_slot) * AW'(BLOCK_BYTES) + AW'(rd_index);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wa] <= wr_data;
      end
      rd_data <= mem[ra];
   end
endmodule
`default_nettype wire

// ===== rtl/xcr_outq.sv =====
`default_nettype none
module xcr_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire xcr_pkg::batch_type in_batch,
   input  wire logic [7:0]         in_read_data,
   output logic                    in_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output xcr_pkg::rsp_type        rsp_data
);
   import xcr_pkg::*;

   // four entry fifo of results; accept a batch when three entries are free
   // after this cycle's pop
   rsp_type    q_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff;
   // read data arrives in the cycle after the batch and is patched in then
   logic       patch_ff;
   logic [1:0] patch_at_ff;

   logic       pop, push, patch_blk;
   logic [2:0] cnt_in;
   rsp_type    e [3];

   assign patch_blk = patch_ff && (patch_at_ff == rd_ff);
   assign pop  = (cnt_ff != 3'd0) && !rsp_stall && !patch_blk;
   assign in_stall = ((cnt_ff - {2'b00, pop}) > 3'd1);
   assign push = in_valid && !in_stall;
   assign rsp_valid = (cnt_ff != 3'd0) && !patch_blk;
   assign rsp_data = q_ff[rd_ff];

   assign e[0] = in_batch.r0;
   assign e[1] = in_batch.r1;
   assign e[2] = in_batch.r2;

   always_comb begin
      cnt_in = cnt_ff - {2'b00, pop} + (push ? {1'b0, in_batch.count} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
         patch_ff <= 1'b0;
         patch_at_ff <= '0;
      end else begin
         if (patch_ff) begin
            q_ff[patch_at_ff].out_byte <= in_read_data;
         end
         patch_ff <= 1'b0;
         if (push) begin
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < in_batch.count) begin
                  q_ff[wr_ff + 2'(i)] <= e[i];
               end
            end
            wr_ff <= wr_ff + in_batch.count;
            if (in_batch.r0.out_kind == KIND_READ && in_batch.count == 2'd1) begin
               patch_ff <= 1'b1;
               patch_at_ff <= wr_ff;
            end
         end
         if (pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/xcr_ctrl.sv =====
`default_nettype none
module xcr_ctrl #(
   parameter int BLOCK_BYTES = xcr_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           go,
   input  wire xcr_pkg::req_type               req,
   input  wire xcr_pkg::cfg_type               cfg,
   output xcr_pkg::batch_type                  batch,
   output logic                                wr_en,
   output logic [1:0]                          wr_slot,
   output logic [$clog2(BLOCK_BYTES)-1:0]      wr_index,
   output logic [7:0]                          wr_data
);
   import xcr_pkg::*;

   localparam int IW = $clog2(BLOCK_BYTES);

   typedef enum logic [3:0] {
      PH_IDLE, PH_INIT, PH_NUM, PH_INV, PH_DATA, PH_CRCHI, PH_CRCLO, PH_HEADER, PH_DRAIN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  retry_ff, retry_in, exp_ff, exp_in, got_ff, got_in, crchi_ff, crchi_in;
   logic [15:0] tick_ff, tick_in, crc_ff, crc_in;
   logic [IW:0] idx_ff, idx_in;
   logic [7:0]  len_ff [3];
   logic [7:0]  len_in [3];
   logic [1:0]  rs_ff, rs_in, hs_ff, hs_in, ls_ff, ls_in;
   logic        hv_ff, hv_in;

   rsp_type     r [3];
   logic [1:0]  n;
   logic [7:0]  b;
   logic [15:0] tk, lim;

   always_comb begin
      phase_in = phase_ff; retry_in = retry_ff; exp_in = exp_ff; got_in = got_ff;
      crchi_in = crchi_ff; tick_in = tick_ff; crc_in = crc_ff; idx_in = idx_ff;
      len_in = len_ff; rs_in = rs_ff; hs_in = hs_ff; ls_in = ls_ff; hv_in = hv_ff;
      r[0] = '0; r[1] = '0; r[2] = '0; n = 2'd0;
      wr_en = 1'b0; wr_slot = rs_ff; wr_index = idx_ff[IW-1:0]; wr_data = req.rx_byte;
      b = req.rx_byte;
      tk = (tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;
      lim = (phase_ff == PH_HEADER) ? cfg.header_to : cfg.byte_to;
      case (req.action)
         ACT_START: begin
            phase_in = PH_INIT; retry_in = '0; tick_in = '0; exp_in = 8'd1; hv_in = 1'b0;
            r[0] = mk(KIND_TX, CH_C, 2'd0, 8'd0, ST_OK); n = 2'd1;
         end
         ACT_READ: begin
            r[0] = mk(KIND_READ, 8'd0, 2'd0, 8'd0, ST_OK); n = 2'd1;
         end
         ACT_TICK: begin
            if (phase_ff != PH_IDLE) begin
               tick_in = tk;
               if (phase_ff == PH_INIT) begin
                  if (tk >= cfg.init_to) begin
                     retry_in = retry_ff + 8'd1; tick_in = '0;
                     if (retry_in >= cfg.retries) begin
                        r[0] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_TIMEOUT);
                        phase_in = PH_IDLE;
                     end else begin
                        r[0] = mk(KIND_TX, CH_C, 2'd0, 8'd0, ST_OK);
                     end
                     n = 2'd1;
                  end
               end else if (tk >= lim) begin
                  r[0] = mk(KIND_TX, CH_CAN, 2'd0, 8'd0, ST_OK);
                  r[1] = r[0];
                  r[2] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_TIMEOUT);
                  n = 2'd3; phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            if (phase_ff != PH_IDLE) begin
               tick_in = '0;
               unique case (phase_ff)
                  PH_INIT: begin
                     if (b == CH_SOH) phase_in = PH_NUM;
                     else if (b == CH_CAN) begin
                        r[0] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_CANCEL); n = 2'd1;
                        phase_in = PH_IDLE;
                     end else begin
                        retry_in = retry_ff + 8'd1;
                        if (retry_in >= cfg.retries) begin
                           r[0] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_TIMEOUT);
                           phase_in = PH_IDLE;
                        end else begin
                           r[0] = mk(KIND_TX, CH_C, 2'd0, 8'd0, ST_OK);
                        end
                        n = 2'd1;
                     end
                  end
                  PH_NUM: begin got_in = b; phase_in = PH_INV; end
                  PH_INV: begin
                     if (got_ff + b != CH_FF) begin
                        r[0] = mk(KIND_TX, CH_NAK, 2'd0, 8'd0, ST_OK); n = 2'd1;
                        phase_in = PH_HEADER;
                     end else begin
                        idx_in = '0; crc_in = '0; phase_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     wr_en = 1'b1;
                     if (idx_ff == '0) len_in[rs_ff] = 8'd0;
                     if (b != CH_SUB) len_in[rs_ff] = 8'(idx_ff) + 8'd1;
                     crc_in = crc_step(crc_ff, b);
                     idx_in = idx_ff + 1'b1;
                     if (idx_in >= (IW+1)'(BLOCK_BYTES)) phase_in = PH_CRCHI;
                  end
                  PH_CRCHI: begin crchi_in = b; phase_in = PH_CRCLO; end
                  PH_CRCLO: begin
                     phase_in = PH_HEADER;
                     if ({crchi_ff, b} != crc_ff) begin
                        r[0] = mk(KIND_TX, CH_NAK, 2'd0, 8'd0, ST_OK); n = 2'd1;
                     end else if (got_ff == exp_ff - 8'd1) begin
                        r[0] = mk(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK); n = 2'd1;
                     end else if (got_ff != exp_ff) begin
                        r[0] = mk(KIND_TX, CH_CAN, 2'd0, 8'd0, ST_OK);
                        r[1] = r[0];
                        r[2] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_SEQ);
                        n = 2'd3; phase_in = PH_IDLE;
                     end else begin
                        r[0] = mk(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK); n = 2'd1;
                        if (hv_ff) begin
                           r[1] = mk(KIND_BLOCK, 8'd0, hs_ff, 8'(BLOCK_BYTES), ST_OK);
                           n = 2'd2;
                        end
                        ls_in = hs_ff; hs_in = rs_ff; rs_in = ls_ff; hv_in = 1'b1;
                        exp_in = exp_ff + 8'd1;
                     end
                  end
                  PH_HEADER, PH_DRAIN: begin
                     if (b == CH_SOH) phase_in = PH_NUM;
                     else if (b == CH_EOT) begin
                        if (hv_ff && len_ff[hs_ff] != 8'd0) begin
                           r[0] = mk(KIND_BLOCK, 8'd0, hs_ff, len_ff[hs_ff], ST_OK);
                           r[1] = mk(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK);
                           r[2] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_OK);
                           n = 2'd3; ls_in = hs_ff; hs_in = ls_ff;
                        end else begin
                           r[0] = mk(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK);
                           r[1] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_OK);
                           n = 2'd2;
                        end
                        hv_in = 1'b0; phase_in = PH_IDLE;
                     end else if (b == CH_CAN) begin
                        r[0] = mk(KIND_FINISH, 8'd0, 2'd0, 8'd0, ST_CANCEL); n = 2'd1;
                        phase_in = PH_IDLE;
                     end else if (phase_ff == PH_HEADER) begin
                        r[0] = mk(KIND_TX, CH_NAK, 2'd0, 8'd0, ST_OK); n = 2'd1;
                        phase_in = PH_DRAIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
      endcase
      case (n)
         2'd1: r[0].last = 1'b1;
         2'd2: r[1].last = 1'b1;
         2'd3: r[2].last = 1'b1;
         default: ;
      endcase
      batch.count = n; batch.r0 = r[0]; batch.r1 = r[1]; batch.r2 = r[2];
      if (!go) wr_en = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; retry_ff <= '0; tick_ff <= '0; exp_ff <= 8'd1;
         got_ff <= '0; idx_ff <= '0; crc_ff <= '0; crchi_ff <= '0;
         for (int i = 0; i < 3; i++) len_ff[i] <= '0;
         rs_ff <= 2'd0; hs_ff <= 2'd1; ls_ff <= 2'd2; hv_ff <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in; retry_ff <= retry_in; tick_ff <= tick_in; exp_ff <= exp_in;
         got_ff <= got_in; idx_ff <= idx_in; crc_ff <= crc_in; crchi_ff <= crchi_in;
         len_ff <= len_in;
         rs_ff <= rs_in; hs_ff <= hs_in; ls_ff <= ls_in; hv_ff <= hv_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/xmodem_crc_receiver.sv =====
`default_nettype none
// xmodem-crc receiver
// path: a request item is registered in the input register; its results are formed
//   combinationally into the output queue, where a read result waits for its store data
// throughput: one request item per cycle while results drain; a request is stalled
//   while more than one result stays in the four-entry output queue after this cycle's pop
// reset: synchronous active high; clears protocol state and config to defaults,
//   the block store is not cleared
module xmodem_crc_receiver #(
   parameter int BLOCK_BYTES = xcr_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire xcr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output xcr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import xcr_pkg::*;

   localparam int IW = $clog2(BLOCK_BYTES);

   // config registers
   cfg_type cfg_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_to <= 16'd500;
         cfg_ff.byte_to <= 16'd1000;
         cfg_ff.header_to <= 16'd3000;
         cfg_ff.retries <= 8'd60;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_INIT_TO:   cfg_ff.init_to <= csr_wdata;
            REG_BYTE_TO:   cfg_ff.byte_to <= csr_wdata;
            REG_HEADER_TO: cfg_ff.header_to <= csr_wdata;
            REG_RETRIES:   cfg_ff.retries <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   logic    in_v_ff;
   req_type in_ff;
   logic    q_stall, go;
   assign req_stall = in_v_ff && q_stall;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (!req_stall) begin
         in_v_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
   end
   assign go = in_v_ff && !q_stall;

   batch_type     batch;
   logic          wr_en;
   logic [1:0]    wr_slot;
   logic [IW-1:0] wr_index;
   logic [7:0]    wr_data, rd_data, rd_mux;
   logic          rd_ok_ff;

   xcr_ctrl #(.BLOCK_BYTES(BLOCK_BYTES)) u_ctrl (
      .clock, .reset, .go, .req(in_ff), .cfg(cfg_ff), .batch,
      .wr_en, .wr_slot, .wr_index, .wr_data
   );

   // store read is issued with the item in the input register
   xcr_store #(.BLOCK_BYTES(BLOCK_BYTES)) u_store (
      .clock, .wr_en, .wr_slot, .wr_index, .wr_data,
      .rd_slot(in_ff.read_buffer), .rd_index(IW'(in_ff.read_index)), .rd_data
   );

   // buffer three reads as zero
   always_ff @(posedge clock) begin
      rd_ok_ff <= (in_ff.read_buffer != 2'd3);
   end
   assign rd_mux = rd_ok_ff ? rd_data : 8'd0;

   xcr_outq u_outq (
      .clock, .reset, .in_valid(in_v_ff), .in_batch(batch), .in_read_data(rd_mux),
      .in_stall(q_stall), .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

// ===== dv/tb_xmodem_crc_receiver.sv =====
`timescale 1ns / 100ps
module tb_xmodem_crc_receiver;
   import xcr_pkg::*;

   localparam int BLK = 128;
   localparam int CYCLE_LIMIT = 400000;

   // block fault kinds used by the transfer generator
   localparam int FLT_NONE  = 0;
   localparam int FLT_INV   = 1;
   localparam int FLT_CRC   = 2;
   localparam int FLT_NOISE = 3;

   // how a transfer is closed
   localparam int END_EOT     = 0;
   localparam int END_CAN     = 1;
   localparam int END_TIMEOUT = 2;
   localparam int END_SEQ     = 3;

   typedef enum logic [3:0] {
      P_IDLE, P_INIT, P_NUM, P_INV, P_DATA, P_CRCHI, P_CRCLO, P_HEADER, P_DRAIN
   } rx_phase_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   req_type   req_data;
   logic      rsp_valid;
   logic      rsp_stall;
   rsp_type   rsp_data;
   logic      csr_valid;
   logic      csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   xmodem_crc_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------
   // receiver model state, a private copy kept in step with the block
   // ---------------------------------------------------------------
   logic [15:0] to_init, to_byte, to_hdr;
   logic [7:0]  retry_max;
   rx_phase_type ph;
   logic [7:0]  tries, exp_num, got_num, crc_hi;
   int          pos;
   logic [15:0] ticks, crc_run;
   logic [7:0]  store [0:3*BLK-1];
   bit          written [0:3*BLK-1];
   logic [7:0]  plen [0:2];
   logic [1:0]  rx_slot, held_slot, rel_slot;
   bit          held_ok;

   rsp_type     step_out[$];     // results of the item being predicted
   rsp_type     rx_expect[$];    // results still owed by the block

   bit          quiet;           // no idling on either side while set
   int          errors;
   int          cycles;

   function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic void put(logic [1:0] k, logic [7:0] b, logic [1:0] id,
                               logic [7:0] len, logic [1:0] st);
      rsp_type r;
      r = '{out_kind: k, out_byte: b, buffer_id: id, block_length: len,
            status: st, last: 1'b0};
      step_out.push_back(r);
   endfunction

   function automatic void finish_xfer(logic [1:0] st);
      put(KIND_FINISH, 8'h00, 2'd0, 8'd0, st);
      ph = P_IDLE;
   endfunction

   // two CANs on the link, then the finish
   function automatic void abort_xfer(logic [1:0] st);
      put(KIND_TX, CH_CAN, 2'd0, 8'd0, ST_OK);
      put(KIND_TX, CH_CAN, 2'd0, 8'd0, ST_OK);
      finish_xfer(st);
   endfunction

   function automatic void start_attempt_failed();
      tries = tries + 8'd1;
      ticks = 16'd0;
      if (tries >= retry_max) finish_xfer(ST_TIMEOUT);
      else put(KIND_TX, CH_C, 2'd0, 8'd0, ST_OK);
   endfunction

   // eot: release held block with sub padding stripped, unless nothing is left
   function automatic void close_on_eot();
      logic [1:0] t;
      if (held_ok && plen[held_slot] != 8'd0) begin
         put(KIND_BLOCK, 8'h00, held_slot, plen[held_slot], ST_OK);
         t = rel_slot;
         rel_slot = held_slot;
         held_slot = t;
      end
      held_ok = 1'b0;
      put(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK);
      finish_xfer(ST_OK);
   endfunction

   function automatic void on_header(logic [7:0] b, bit draining);
      if (b == CH_SOH) ph = P_NUM;
      else if (b == CH_EOT) close_on_eot();
      else if (b == CH_CAN) finish_xfer(ST_CANCEL);
      else if (!draining) begin
         put(KIND_TX, CH_NAK, 2'd0, 8'd0, ST_OK);
         ph = P_DRAIN;
      end
   endfunction

   // crc low byte arrived: judge the block
   function automatic void on_block_end(logic [7:0] lo);
      logic [1:0] t;
      ph = P_HEADER;
      if ({crc_hi, lo} != crc_run) put(KIND_TX, CH_NAK, 2'd0, 8'd0, ST_OK);
      else if (got_num == exp_num - 8'd1) put(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK);
      else if (got_num != exp_num) abort_xfer(ST_SEQ);
      else begin
         put(KIND_TX, CH_ACK, 2'd0, 8'd0, ST_OK);
         // release runs one good block late
         if (held_ok) put(KIND_BLOCK, 8'h00, held_slot, 8'd128, ST_OK);
         t = rel_slot;
         rel_slot = held_slot;
         held_slot = rx_slot;
         rx_slot = t;
         held_ok = 1'b1;
         exp_num = exp_num + 8'd1;
      end
   endfunction

   function automatic void on_rx_byte(logic [7:0] b);
      int a;
      if (ph == P_IDLE) return;
      ticks = 16'd0;
      case (ph)
         P_INIT: begin
            if (b == CH_SOH) ph = P_NUM;
            else if (b == CH_CAN) finish_xfer(ST_CANCEL);
            else start_attempt_failed();
         end
         P_NUM: begin
            got_num = b;
            ph = P_INV;
         end
         P_INV: begin
            if (got_num + b != CH_FF) begin
               put(KIND_TX, CH_NAK, 2'd0, 8'd0, ST_OK);
               ph = P_HEADER;
            end else begin
               pos = 0;
               crc_run = 16'd0;
               ph = P_DATA;
            end
         end
         P_DATA: begin
            a = rx_slot * BLK + pos;
            if (pos == 0) plen[rx_slot] = 8'd0;
            store[a] = b;
            written[a] = 1'b1;
            if (b != CH_SUB) plen[rx_slot] = 8'(pos + 1);
            crc_run = crc_next(crc_run, b);
            pos++;
            if (pos >= BLK) ph = P_CRCHI;
         end
         P_CRCHI: begin
            crc_hi = b;
            ph = P_CRCLO;
         end
         P_CRCLO: on_block_end(b);
         P_HEADER: on_header(b, 1'b0);
         default: on_header(b, 1'b1);
      endcase
   endfunction

   function automatic void on_tick();
      logic [15:0] lim;
      if (ph == P_IDLE) return;
      if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
      if (ph == P_INIT) begin
         if (ticks >= to_init) start_attempt_failed();
         return;
      end
      lim = (ph == P_HEADER) ? to_hdr : to_byte;
      if (ticks >= lim) abort_xfer(ST_TIMEOUT);
   endfunction

   // works out the results of one accepted item and queues them
   function automatic void predict_item(req_type d);
      logic [7:0] v;
      step_out.delete();
      case (d.action)
         ACT_START: begin
            ph = P_INIT;
            tries = 8'd0;
            ticks = 16'd0;
            exp_num = 8'd1;
            held_ok = 1'b0;
            put(KIND_TX, CH_C, 2'd0, 8'd0, ST_OK);
         end
         ACT_BYTE: on_rx_byte(d.rx_byte);
         ACT_TICK: on_tick();
         default: begin
            v = 8'h00;
            if (d.read_buffer != 2'd3) v = store[d.read_buffer * BLK + d.read_index];
            put(KIND_READ, v, 2'd0, 8'd0, ST_OK);
         end
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) rx_expect.push_back(step_out[i]);
   endfunction

   // ---------------------------------------------------------------
   // result side: random stall and in-order compare
   // ---------------------------------------------------------------
   int stall_left;

   always @(posedge clock) begin
      rsp_type want;
      int      n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (rx_expect.size() == 0) begin
            if (errors < 10)
               $display("unexpected result kind=%0d byte=%h id=%0d len=%0d st=%0d last=%0d",
                        rsp_data.out_kind, rsp_data.out_byte, rsp_data.buffer_id,
                        rsp_data.block_length, rsp_data.status, rsp_data.last);
            errors++;
         end else begin
            want = rx_expect.pop_front();
            if (rsp_data.out_kind !== want.out_kind || rsp_data.out_byte !== want.out_byte ||
                rsp_data.buffer_id !== want.buffer_id ||
                rsp_data.block_length !== want.block_length ||
                rsp_data.status !== want.status || rsp_data.last !== want.last) begin
               if (errors < 10) begin
                  $display("mismatch exp kind=%0d byte=%h id=%0d len=%0d st=%0d last=%0d",
                           want.out_kind, want.out_byte, want.buffer_id,
                           want.block_length, want.status, want.last);
                  $display("         got kind=%0d byte=%h id=%0d len=%0d st=%0d last=%0d",
                           rsp_data.out_kind, rsp_data.out_byte, rsp_data.buffer_id,
                           rsp_data.block_length, rsp_data.status, rsp_data.last);
               end
               errors++;
            end
         end
         // fresh stall length for the next result
         n = quiet ? 0 : $urandom_range(0, 15);
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("xmodem_crc_receiver regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one item: random gap, hold until not stalled, then predict
   task automatic send_item(logic [1:0] act, logic [7:0] b, logic [1:0] rb, logic [6:0] ri);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{action: act, rx_byte: b, read_buffer: rb, read_index: ri};
      do @(posedge clock); while (req_stall);
      predict_item('{action: act, rx_byte: b, read_buffer: rb, read_index: ri});
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(ACT_BYTE, b, 2'($urandom), 7'($urandom));
   endtask

   task automatic send_tick();
      send_item(ACT_TICK, 8'($urandom), 2'($urandom), 7'($urandom));
   endtask

   // reads only entries that hold data; buffer three always reads zero
   task automatic send_read();
      logic [1:0] rb;
      logic [6:0] ri;
      rb = 2'($urandom_range(0, 3));
      ri = 7'($urandom_range(0, 127));
      if (rb != 2'd3 && !written[rb * BLK + ri]) rb = 2'd3;
      send_item(ACT_READ, 8'($urandom), rb, ri);
   endtask

   task automatic send_start();
      send_item(ACT_START, 8'($urandom), 2'($urandom), 7'($urandom));
   endtask

   // wait until the block owes nothing, plus its latency
   task automatic settle();
      req_valid <= 1'b0;
      while (rx_expect.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // all four registers, back to back, only while idle
   task automatic set_regs(logic [15:0] ini, logic [15:0] byt, logic [15:0] hdr,
                           logic [7:0] rtr);
      logic [15:0] vals [4];
      logic [1:0]  idx [4];
      vals = '{ini, byt, hdr, {8'h00, rtr}};
      idx = '{REG_INIT_TO, REG_BYTE_TO, REG_HEADER_TO, REG_RETRIES};
      settle();
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      to_init = ini;
      to_byte = byt;
      to_hdr = hdr;
      retry_max = rtr;
   endtask

   // one framed block; pad sets how many trailing bytes are sub
   task automatic send_block(logic [7:0] num, int pad, int fault);
      logic [7:0]  b;
      logic [15:0] crc;
      crc = 16'd0;
      if (fault == FLT_NOISE) begin
         // garbage: a nak, then drained; or failed start tries before block one
         send_byte(8'h30 + 8'($urandom_range(0, 15)));
         send_byte(8'h80 | 8'($urandom));
      end
      send_byte(CH_SOH);
      send_byte(num);
      if (fault == FLT_INV) begin
         send_byte(~num ^ 8'(1 << $urandom_range(0, 7)));
         return;
      end
      send_byte(~num);
      for (int i = 0; i < BLK; i++) begin
         b = (i >= BLK - pad) ? CH_SUB : 8'($urandom);
         crc = crc_next(crc, b);
         send_byte(b);
         if ($urandom_range(0, 63) == 0) send_tick();
      end
      if (fault == FLT_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
   endtask

   // a whole transfer: start, blocks with short random faults, a chosen ending
   task automatic run_transfer(int nblk, int ending);
      logic [7:0] num;
      int         f;
      send_start();
      if (retry_max > 1 && $urandom_range(0, 2) == 0) send_byte(8'h43);
      num = 8'd1;
      for (int k = 0; k < nblk; k++) begin
         f = $urandom_range(0, 2);
         if (f == 1) send_block(num, 0, FLT_INV);
         send_block(num, (k == nblk - 1) ? $urandom_range(0, 128) : 0,
                    (f == 2) ? FLT_NOISE : FLT_NONE);
         num = num + 8'd1;
         repeat ($urandom_range(0, 2)) send_read();
      end
      case (ending)
         END_EOT: send_byte(CH_EOT);
         END_CAN: send_byte(CH_CAN);
         END_SEQ: send_block(num + 8'd5, 0, FLT_NONE);
         default: repeat (to_hdr) send_tick();
      endcase
      repeat (3) send_read();
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // start handshake, retries, cancel, restart, idle and error paths
   task automatic test_directed();
      set_regs(16'd1, 16'd1, 16'd1, 8'd2);
      send_tick();                      // idle: ignored
      send_byte(CH_SOH);                // idle: ignored
      send_item(ACT_READ, 8'h00, 2'd3, 7'd127);
      send_start();
      send_tick();                      // first attempt expires
      send_byte(8'hFF);                 // stray byte ends the retries
      send_start();
      send_byte(CH_CAN);                // cancelled before any block
      send_start();
      send_start();                     // restart while active
      send_byte(CH_SOH);
      send_byte(8'h01);
      send_byte(8'h00);                 // bad complement
      send_byte(8'h55);                 // garbage header
      send_byte(8'hFF);                 // drained
      send_tick();                      // drain timeout
      send_start();
      send_byte(CH_SOH);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(8'h00);
      send_tick();                      // timeout inside the data
      send_item(ACT_READ, 8'hFF, 2'd0, 7'd0);
   endtask

   // widest settings, no idling at all, one block with padding stripped on eot
   task automatic test_wide_regs();
      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
      quiet = 1'b1;
      run_transfer(1, END_EOT);
      quiet = 1'b0;
   endtask

   // short timeouts, random idling, retries, data timeout, header cancel
   task automatic test_short_regs();
      set_regs(16'd3, 16'd4, 16'd4, 8'd3);
      send_start();
      repeat (10) send_tick();          // retries run out on ticks
      send_start();
      send_byte(CH_SOH);
      send_byte(8'h01);
      send_byte(8'hFE);
      repeat (4) send_byte(8'($urandom));
      repeat (4) send_tick();           // timeout inside the data
      send_start();
      send_byte(CH_SOH);
      send_byte(8'h02);
      send_byte(8'h00);                 // bad complement
      send_byte(CH_CAN);                // cancelled while waiting for a header
      repeat (4) send_read();
   endtask

   // narrowest settings: every tick is a timeout, one attempt only
   task automatic test_narrow_regs();
      set_regs(16'd1, 16'd1, 16'd1, 8'd1);
      send_start();
      send_tick();
      send_start();
      send_byte(8'h00);
      repeat (10) send_read();
   endtask

   // mid settings: header timeout, stray byte at start, restart inside the data
   task automatic test_header_timeout();
      set_regs(16'd200, 16'd300, 16'd2, 8'd60);
      send_start();
      send_byte(CH_SOH);
      send_byte(8'h01);
      send_byte(8'h00);                 // bad complement
      send_tick();
      send_tick();                      // header wait expires
      send_start();
      send_byte(8'h55);                 // stray byte, 'C' again
      send_byte(CH_SOH);
      send_byte(8'h01);
      send_byte(8'hFE);
      repeat (3) send_byte(8'($urandom));
      send_start();                     // restart inside the data
      repeat (10) send_read();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_INIT_TO;
      csr_wdata = 16'd0;
      // model defaults match the block after reset
      to_init = 16'd500;
      to_byte = 16'd1000;
      to_hdr = 16'd3000;
      retry_max = 8'd60;
      ph = P_IDLE;
      tries = 8'd0;
      ticks = 16'd0;
      exp_num = 8'd1;
      got_num = 8'd0;
      pos = 0;
      crc_run = 16'd0;
      crc_hi = 8'd0;
      for (int i = 0; i < 3 * BLK; i++) begin
         store[i] = 8'h00;
         written[i] = 1'b0;
      end
      plen = '{8'd0, 8'd0, 8'd0};
      rx_slot = 2'd0;
      held_slot = 2'd1;
      rel_slot = 2'd2;
      held_ok = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_wide_regs();
      test_short_regs();
      test_narrow_regs();
      test_header_timeout();

      settle();
      if (errors == 0 && rx_expect.size() == 0) begin
         $display("xmodem_crc_receiver regression: pass");
      end else begin
         $display("xmodem_crc_receiver regression: fail");
      end
      $finish;
   end

endmodule
